FILE: rtl/lhst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhst_pkg
// shared types and constants of the link health slot table
// ----------------------------------------------------------------------------
package lhst_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int MAX_REC        = 8;
  localparam int MS_PER_S       = 1000;
  localparam int STALE_RESET    = 30;
  localparam int STALE_MS_W     = 26;

  localparam logic [2:0] MODE_REG  = 3'd0;
  localparam logic [2:0] MODE_SET  = 3'd1;
  localparam logic [2:0] MODE_REP  = 3'd2;
  localparam logic [2:0] MODE_ACT  = 3'd3;
  localparam logic [2:0] MODE_SNAP = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  localparam logic [3:0] NO_HANDLE = 4'd15;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  handle;
    logic [1:0]  link_class;
    logic        flag;
    logic [63:0] now_ms;
    logic [3:0]  snapshot_limit;
  } lhst_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_handle;
    logic        slot_class;
    logic        slot_enabled;
    logic        slot_failing;
    logic [63:0] last_ok_time;
    logic [31:0] failures;
    logic [63:0] last_rx_time;
    logic [31:0] rx_events;
    logic        last_record;
    logic [3:0]  enabled_total;
    logic [3:0]  failing_total;
  } lhst_out_t;

  // request travelling down the row of slots
  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  handle;
    logic [1:0]  link_class;
    logic        flag;
    logic [63:0] now_ms;
    logic        claimed;
    logic [3:0]  hit_handle;
    logic        hit;
    logic [3:0]  en_cnt;
    logic [3:0]  bad_cnt;
  } lhst_probe_t;

  typedef struct packed {
    logic        used;
    logic        kind;
    logic        on;
    logic        bad;
    logic [63:0] ok_stamp;
    logic [31:0] fail_tally;
    logic [63:0] rx_stamp;
    logic [31:0] rx_tally;
  } lhst_slot_t;

endpackage

FILE: rtl/lhst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhst_in_if / lhst_out_if
// valid-ready channels for requests and results
// ----------------------------------------------------------------------------
interface lhst_in_if import lhst_pkg::*; ();
  logic     valid;
  logic     ready;
  lhst_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lhst_out_if import lhst_pkg::*; ();
  logic      valid;
  logic      ready;
  lhst_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/link_health_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_health_slot_table
// table of link health slots held in a row of cells
// ----------------------------------------------------------------------------
// a request walks the row one slot per cycle
// a snapshot then reads the slots in order, one slot per cycle unless the receiver holds back a result
// one request at a time
// synchronous reset frees all slots and sets the stale limit to 30 s (stale_ms = 30000)
module link_health_slot_table import lhst_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  lhst_in_if.sink     in_ch,
  lhst_out_if.source  out_ch
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_FIN  = 4'b0100,
    S_SNAP = 4'b1000
  } state_t;

  state_t               state;
  logic [STALE_MS_W-1:0] stale_ms;
  logic                 chain_valid [SLOT_COUNT+1];
  lhst_probe_t          chain [SLOT_COUNT+1];
  lhst_slot_t           slots [SLOT_COUNT];
  lhst_probe_t          res;
  logic [3:0]           lim;
  logic [CW-1:0]        idx;
  logic [3:0]           cnt;
  lhst_slot_t           cur;
  logic                 out_free;
  logic                 more;
  logic                 stale;
  logic [63:0]          diff;
  logic [1:0]           status_fin;
  lhst_out_t            fin_data;

  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      lhst_cell #(.IDX(g)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .pin_valid  (chain_valid[g]),
        .pin        (chain[g]),
        .pout_valid (chain_valid[g+1]),
        .pout       (chain[g+1]),
        .slot       (slots[g])
      );
    end
  endgenerate

  assign in_ch.ready = (state == S_IDLE);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign cur         = slots[idx[IW-1:0]];

  always_comb begin
    more = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (CW'(i) > idx && slots[i].used) more = 1'b1;
    end
    diff  = res.now_ms - cur.rx_stamp;
    stale = (res.now_ms > cur.rx_stamp) && (diff > {{(64-STALE_MS_W){1'b0}}, stale_ms});
    if (res.mode == MODE_REG) begin
      status_fin = (res.link_class > 2'd1) ? ST_INVALID :
                   (res.claimed ? ST_OK : ST_NO_SPACE);
    end else if (res.mode == MODE_SET || res.mode == MODE_REP || res.mode == MODE_ACT) begin
      status_fin = res.hit ? ST_OK : ST_INVALID;
    end else begin
      status_fin = ST_INVALID;
    end
    fin_data               = '0;
    fin_data.status        = status_fin;
    fin_data.slot_handle   = (status_fin == ST_OK) ? res.hit_handle : NO_HANDLE;
    fin_data.last_record   = 1'b1;
    fin_data.enabled_total = res.en_cnt;
    fin_data.failing_total = res.bad_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stale_ms       <= STALE_MS_W'(STALE_RESET * MS_PER_S);
      chain_valid[0] <= 1'b0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (cfg_we) stale_ms <= STALE_MS_W'(cfg_wdata * MS_PER_S);
      chain_valid[0] <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            chain_valid[0] <= 1'b1;
            state          <= S_WALK;
          end
        end
        S_WALK: begin
          if (chain_valid[SLOT_COUNT]) state <= S_FIN;
        end
        S_FIN: begin
          if (res.mode == MODE_SNAP) begin
            state <= (lim == 4'd0) ? S_IDLE : S_SNAP;
          end else if (out_free) begin
            out_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_SNAP: begin
          if (idx >= CW'(SLOT_COUNT)) begin
            state <= S_IDLE;
          end else if (cur.used && out_free) begin
            out_ch.valid <= 1'b1;
            if (!more || (cnt + 4'd1 == lim)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (state == S_IDLE && in_ch.valid) begin
      chain[0].mode       <= in_ch.data.mode;
      chain[0].handle     <= in_ch.data.handle;
      chain[0].link_class <= in_ch.data.link_class;
      chain[0].flag       <= in_ch.data.flag;
      chain[0].now_ms     <= in_ch.data.now_ms;
      chain[0].claimed    <= 1'b0;
      chain[0].hit_handle <= NO_HANDLE;
      chain[0].hit        <= 1'b0;
      chain[0].en_cnt     <= 4'd0;
      chain[0].bad_cnt    <= 4'd0;
      lim <= (in_ch.data.snapshot_limit > 4'(MAX_REC)) ? 4'(MAX_REC)
                                                       : in_ch.data.snapshot_limit;
      idx <= '0;
      cnt <= 4'd0;
    end
    if (state == S_WALK && chain_valid[SLOT_COUNT]) res <= chain[SLOT_COUNT];
    if (state == S_FIN && res.mode != MODE_SNAP && out_free) begin
      out_ch.data <= fin_data;
    end
    if (state == S_SNAP && idx < CW'(SLOT_COUNT)) begin
      if (!cur.used) begin
        idx <= idx + CW'(1);
      end else if (out_free) begin
        idx <= idx + CW'(1);
        cnt <= cnt + 4'd1;
        out_ch.data.status        <= ST_OK;
        out_ch.data.slot_handle   <= 4'(idx);
        out_ch.data.slot_class    <= cur.kind;
        out_ch.data.slot_enabled  <= cur.on;
        out_ch.data.slot_failing  <= cur.kind ? stale : cur.bad;
        out_ch.data.last_ok_time  <= cur.ok_stamp;
        out_ch.data.failures      <= cur.fail_tally;
        out_ch.data.last_rx_time  <= cur.rx_stamp;
        out_ch.data.rx_events     <= cur.rx_tally;
        out_ch.data.last_record   <= !more || (cnt + 4'd1 == lim);
        out_ch.data.enabled_total <= res.en_cnt;
        out_ch.data.failing_total <= res.bad_cnt;
      end
    end
  end

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_WALK)
    else $error("accepted request did not start a walk");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    chain_valid[SLOT_COUNT] |-> chain[SLOT_COUNT].bad_cnt <= chain[SLOT_COUNT].en_cnt)
    else $error("failing total above enabled total");

  a_snap_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_SNAP |-> cnt < lim)
    else $error("snapshot past its limit");

  a_walk_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !chain_valid[SLOT_COUNT])
    else $error("request left the row while idle");

endmodule

FILE: rtl/lhst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhst_cell
// one slot: applies a passing request and, if it is an enabled class 0 slot, adds itself to the running totals
// ----------------------------------------------------------------------------
module lhst_cell import lhst_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pin_valid,
  input  lhst_probe_t pin,
  output logic        pout_valid,
  output lhst_probe_t pout,
  output lhst_slot_t  slot
);

  localparam logic [3:0] MY_HANDLE = 4'(IDX);

  lhst_slot_t  slot_next;
  lhst_probe_t pout_next;
  logic        claim;
  logic        hit;

  always_comb begin
    claim = (pin.mode == MODE_REG) && (pin.link_class <= 2'd1) && !pin.claimed && !slot.used;
    hit = (pin.handle == MY_HANDLE) && slot.used &&
          ((pin.mode == MODE_SET) || ((pin.mode == MODE_REP) && !slot.kind) ||
           ((pin.mode == MODE_ACT) && slot.kind));
    slot_next = slot;
    if (claim) begin
      slot_next.used       = 1'b1;
      slot_next.kind       = pin.link_class[0];
      slot_next.on         = 1'b1;
      slot_next.bad        = 1'b0;
      slot_next.ok_stamp   = '0;
      slot_next.fail_tally = '0;
      slot_next.rx_stamp   = '0;
      slot_next.rx_tally   = '0;
    end else if (hit) begin
      case (pin.mode)
        MODE_SET: slot_next.on = pin.flag;
        MODE_REP: begin
          if (pin.flag) begin
            slot_next.bad      = 1'b0;
            slot_next.ok_stamp = pin.now_ms;
          end else begin
            slot_next.bad        = 1'b1;
            slot_next.fail_tally = slot.fail_tally + 32'd1;
          end
        end
        MODE_ACT: begin
          slot_next.rx_stamp = pin.now_ms;
          slot_next.rx_tally = slot.rx_tally + 32'd1;
        end
        default: slot_next = slot;
      endcase
    end
    pout_next = pin;
    if (claim) begin
      pout_next.claimed    = 1'b1;
      pout_next.hit_handle = MY_HANDLE;
    end
    if (hit) begin
      pout_next.hit        = 1'b1;
      pout_next.hit_handle = MY_HANDLE;
    end
    if (slot_next.used && !slot_next.kind && slot_next.on) begin
      pout_next.en_cnt = pin.en_cnt + 4'd1;
      if (slot_next.bad) pout_next.bad_cnt = pin.bad_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.used  <= 1'b0;
      slot.kind  <= 1'b0;
      slot.on    <= 1'b0;
      slot.bad   <= 1'b0;
      pout_valid <= 1'b0;
    end else begin
      pout_valid <= pin_valid;
      if (pin_valid) begin
        slot.used <= slot_next.used;
        slot.kind <= slot_next.kind;
        slot.on   <= slot_next.on;
        slot.bad  <= slot_next.bad;
      end
    end
    if (pin_valid) begin
      slot.ok_stamp   <= slot_next.ok_stamp;
      slot.fail_tally <= slot_next.fail_tally;
      slot.rx_stamp   <= slot_next.rx_stamp;
      slot.rx_tally   <= slot_next.rx_tally;
      pout            <= pout_next;
    end
  end

endmodule

FILE: verif/link_health_slot_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_health_slot_table_checker
// watches the request and result channels, predicts every result of the
// slot table from its own copy of the slots and compares each result as a whole
// ----------------------------------------------------------------------------
module link_health_slot_table_checker import lhst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  lhst_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  lhst_out_t   out_data,
  output int          mismatches,
  output int          pending
);

  localparam int NSLOT = SLOT_COUNT_DEF;

  lhst_slot_t slots [NSLOT];
  logic [15:0] stale_sec;
  lhst_out_t expected_results [$];

  assign pending = expected_results.size();

  function automatic void count_totals(output logic [3:0] en, output logic [3:0] bad);
    en = 0;
    bad = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (slots[i].used && !slots[i].kind && slots[i].on) begin
        en++;
        if (slots[i].bad) bad++;
      end
    end
  endfunction

  function automatic logic is_stale(logic [63:0] rx, logic [63:0] now);
    logic [63:0] lim_ms;
    lim_ms = 64'(stale_sec) * 64'd1000;
    if (now <= rx) return 1'b0;
    return (now - rx) > lim_ms;
  endfunction

  task automatic predict_request(input lhst_in_t req);
    lhst_out_t r;
    logic [3:0] en, bad, lim;
    logic ok;
    int n, first;
    r = '0;
    r.status = ST_INVALID;
    r.slot_handle = NO_HANDLE;
    ok = req.handle < NSLOT && slots[req.handle].used;
    if (req.mode == MODE_SNAP) begin
      lim = req.snapshot_limit > MAX_REC ? 4'(MAX_REC) : req.snapshot_limit;
      count_totals(en, bad);
      n = 0;
      first = expected_results.size();
      for (int i = 0; i < NSLOT && n < lim; i++) begin
        if (!slots[i].used) continue;
        r = '0;
        r.status = ST_OK;
        r.slot_handle = 4'(i);
        r.slot_class = slots[i].kind;
        r.slot_enabled = slots[i].on;
        r.slot_failing = slots[i].kind ? is_stale(slots[i].rx_stamp, req.now_ms)
                                       : slots[i].bad;
        r.last_ok_time = slots[i].ok_stamp;
        r.failures = slots[i].fail_tally;
        r.last_rx_time = slots[i].rx_stamp;
        r.rx_events = slots[i].rx_tally;
        r.enabled_total = en;
        r.failing_total = bad;
        expected_results.push_back(r);
        n++;
      end
      if (n > 0) expected_results[first + n - 1].last_record = 1'b1;
      return;
    end
    case (req.mode)
      MODE_REG: begin
        if (req.link_class <= 1) begin
          r.status = ST_NO_SPACE;
          for (int i = 0; i < NSLOT; i++) begin
            if (slots[i].used) continue;
            slots[i] = '0;
            slots[i].used = 1'b1;
            slots[i].kind = req.link_class[0];
            slots[i].on = 1'b1;
            r.status = ST_OK;
            r.slot_handle = 4'(i);
            break;
          end
        end
      end
      MODE_SET: if (ok) begin
        slots[req.handle].on = req.flag;
        r.status = ST_OK;
        r.slot_handle = req.handle;
      end
      MODE_REP: if (ok && !slots[req.handle].kind) begin
        if (req.flag) begin
          slots[req.handle].bad = 1'b0;
          slots[req.handle].ok_stamp = req.now_ms;
        end else begin
          slots[req.handle].bad = 1'b1;
          slots[req.handle].fail_tally++;
        end
        r.status = ST_OK;
        r.slot_handle = req.handle;
      end
      MODE_ACT: if (ok && slots[req.handle].kind) begin
        slots[req.handle].rx_stamp = req.now_ms;
        slots[req.handle].rx_tally++;
        r.status = ST_OK;
        r.slot_handle = req.handle;
      end
      default: ;
    endcase
    count_totals(en, bad);
    r.last_record = 1'b1;
    r.enabled_total = en;
    r.failing_total = bad;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input lhst_out_t exp_r, input lhst_out_t act);
    if (mismatches < 10)
      $display("mismatch %s: expected %p actual %p", what, exp_r, act);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lhst_out_t exp_r;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) slots[i] = '0;
      stale_sec = 16'(STALE_RESET);
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) stale_sec = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_data);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data !== exp_r) report_mismatch("result", exp_r, out_data);
        end
      end
      if (in_valid && in_ready) predict_request(in_data);
    end
  end

endmodule

FILE: verif/link_health_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_health_slot_table_tb
// drives registers, directed and random requests with random gaps and
// stalls into the slot table; the checker predicts and compares results
// ----------------------------------------------------------------------------
module link_health_slot_table_tb;
  import lhst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int mismatches, pending;
  int cycles = 0;
  logic long_hold = 1'b0;
  logic [63:0] clock_ms = 64'd5000;

  lhst_in_if in_ch ();
  lhst_out_if out_ch ();

  link_health_slot_table i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  link_health_slot_table_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("link_health_slot_table regression: fail");
      $finish;
    end
  end

  // receiver: random stalls per result, plus one long hold-off
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // valid stays up between back-to-back requests; drain drops it
  task automatic send(input lhst_in_t req, input bit no_gap = 0);
    int w;
    w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (w > 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic lhst_in_t make_req(logic [2:0] m, logic [3:0] h, logic [1:0] c,
                                        logic f, logic [63:0] t, logic [3:0] l);
    lhst_in_t r;
    r.mode = m;
    r.handle = h;
    r.link_class = c;
    r.flag = f;
    r.now_ms = t;
    r.snapshot_limit = l;
    return r;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_stale(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic lhst_in_t random_req();
    logic [2:0] m;
    logic [63:0] t;
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) m = MODE_REG;
    else if (k < 20) m = MODE_SET;
    else if (k < 50) m = MODE_REP;
    else if (k < 78) m = MODE_ACT;
    else if (k < 95) m = MODE_SNAP;
    else m = 3'($urandom_range(5, 7));
    k = $urandom_range(0, 9);
    if (k == 0) t = {$urandom, $urandom};
    else if (k == 1) t = clock_ms - 64'($urandom_range(0, 100000));
    else begin
      clock_ms = clock_ms + 64'($urandom_range(0, 40000));
      t = clock_ms;
    end
    return make_req(m,
                    ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, 7)),
                    ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1)),
                    1'($urandom), t,
                    ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'(MAX_REC));
  endfunction

  initial begin
    logic [15:0] stale_set [4] = '{16'd0, 16'hffff, 16'd5, 16'd60};
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    send(make_req(MODE_SNAP, 0, 0, 0, 0, 8));
    send(make_req(MODE_SET, 0, 0, 1, 0, 0));
    send(make_req(MODE_REG, 0, 2, 0, 0, 0));
    send(make_req(MODE_REG, 0, 3, 0, 0, 0));
    for (int i = 0; i < 8; i++) send(make_req(MODE_REG, 0, 2'(i % 2), 0, 0, 0));
    send(make_req(MODE_REG, 0, 0, 0, 0, 0));
    send(make_req(MODE_REP, 1, 0, 1, 64'd100, 0));
    send(make_req(MODE_ACT, 0, 0, 0, 64'd100, 0));
    send(make_req(MODE_REP, 0, 0, 0, '1, 0));
    send(make_req(MODE_REP, 0, 0, 1, '1, 0));
    send(make_req(MODE_ACT, 1, 0, 0, 64'd1000, 0));
    send(make_req(MODE_SET, 15, 0, 1, 0, 0));
    send(make_req(3'd5, 0, 0, 0, 0, 0));
    send(make_req(3'd7, 0, 0, 1, 0, 0));
    send(make_req(MODE_SNAP, 0, 0, 0, 64'd31001, 0));
    send(make_req(MODE_SNAP, 0, 0, 0, 64'd31001, 15));
    send(make_req(MODE_SNAP, 0, 0, 0, 64'd31000, 3));
    send(make_req(MODE_SET, 7, 3, 0, 0, 0));
    drain();

    // random phases over several stale settings, one long receiver hold
    for (int p = 0; p < 4; p++) begin
      write_stale(stale_set[p]);
      if (p == 1) long_hold = 1'b1;
      for (int n = 0; n < 110; n++) send(random_req(), p == 1 && n < 40);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("link_health_slot_table regression: pass");
    end else begin
      $display("link_health_slot_table regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lhst_pkg.sv
rtl/lhst_if.sv
rtl/lhst_cell.sv
rtl/link_health_slot_table.sv
verif/link_health_slot_table_checker.sv
verif/link_health_slot_table_tb.sv
